// ----- src/assert_macros.svh -----
// Assertion macros shared by the deframer queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define LPDQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Plain invariant, written as a condition.
`define LPDQ_INVARIANT(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

`else

`define LPDQ_ASSERT(lbl, clk, rstn, prop, msg)
`define LPDQ_INVARIANT(lbl, clk, rstn, cond, msg)

`endif

`endif

// ----- src/lpdq_pkg.sv -----
// Package: constants, codes and types of the packet deframer queue.
`default_nettype none

package lpdq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16384;
  localparam int unsigned ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CMP_W       = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned COUNT_OUT_W = 15;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd8205;
  localparam logic [LEN_W-1:0] MIN_LEN       = 16'd2;

  localparam logic KIND_RX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_TAKEN   = 3'd0,
    ST_COMMIT  = 3'd1,
    ST_DROP    = 3'd2,
    ST_CORRUPT = 3'd3,
    ST_READ    = 3'd4,
    ST_EMPTY   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_LEN_LO = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  // Request from the top level into the ring control.
  typedef struct packed {
    logic              rx_en;
    logic              pop;
    logic [BYTE_W-1:0] rx_byte;
  } ctl_req_t;

  // Ring write port.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } ring_wr_t;

  // Request state carried to the read-data stage.
  typedef struct packed {
    status_e                status;
    logic [COUNT_OUT_W-1:0] committed;
  } item_t;

  function automatic logic [ADDR_W-1:0] ptr_adv(input logic [ADDR_W-1:0] ptr);
    logic [ADDR_W-1:0] nxt;
    if (ptr == ADDR_W'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ----- src/lpdq_if.sv -----
// Valid/ready channel interfaces of the deframer queue.
`default_nettype none

interface lpdq_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface lpdq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  read_data;
  logic        last_of_report;
  logic [14:0] committed_bytes;

  modport source (output valid, output status, output read_data, output last_of_report,
                  output committed_bytes, input ready);
  modport sink   (input valid, input status, input read_data, input last_of_report,
                  input committed_bytes, output ready);
endinterface

`default_nettype wire

// ----- src/lpdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lpdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/lpdq_ctl.sv -----
// Ring control: length parsing, pending/commit/read pointers, committed count.
`default_nettype none
`include "assert_macros.svh"

module lpdq_ctl (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [lpdq_pkg::LEN_W-1:0]       max_len_i,
  input  wire lpdq_pkg::ctl_req_t               req_i,
  output lpdq_pkg::status_e                     rx_status_o,
  output lpdq_pkg::ring_wr_t                    wr_o,
  output logic      [lpdq_pkg::ADDR_W-1:0]      rd_ptr_o,
  output logic      [lpdq_pkg::CNT_W-1:0]       count_o,
  output logic      [lpdq_pkg::CNT_W-1:0]       count_next_o
);

  logic [lpdq_pkg::ADDR_W-1:0] commit_q, commit_d;
  logic [lpdq_pkg::ADDR_W-1:0] pend_q, pend_d;
  logic [lpdq_pkg::ADDR_W-1:0] rd_q, rd_d;
  logic [lpdq_pkg::CNT_W-1:0]  count_q, count_d;
  lpdq_pkg::phase_e            phase_q, phase_d;
  logic [lpdq_pkg::LEN_W-1:0]  pkt_len_q, pkt_len_d;
  logic [lpdq_pkg::LEN_W-1:0]  left_q, left_d;
  logic                        drop_q, drop_d;

  logic [lpdq_pkg::LEN_W-1:0]  len_hi;
  logic [lpdq_pkg::LEN_W-1:0]  left_dec;
  logic [lpdq_pkg::CMP_W-1:0]  free_space;
  logic                        no_room;

  assign len_hi     = {req_i.rx_byte, pkt_len_q[7:0]};
  assign left_dec   = left_q - 1'b1;
  assign free_space = lpdq_pkg::CMP_W'(lpdq_pkg::QUEUE_DEPTH) - lpdq_pkg::CMP_W'(count_q);
  assign no_room    = lpdq_pkg::CMP_W'(len_hi) > free_space;

  always_comb begin
    commit_d    = commit_q;
    pend_d      = pend_q;
    rd_d        = rd_q;
    count_d     = count_q;
    phase_d     = phase_q;
    pkt_len_d   = pkt_len_q;
    left_d      = left_q;
    drop_d      = drop_q;
    wr_o        = '0;
    rx_status_o = lpdq_pkg::ST_TAKEN;

    if (req_i.rx_en) begin
      case (phase_q)
        lpdq_pkg::PH_LEN_LO: begin
          pkt_len_d = {8'h00, req_i.rx_byte};
          pend_d    = commit_q;
          // low byte lands only if the slot after the committed data is free
          if (count_q < lpdq_pkg::CNT_W'(lpdq_pkg::QUEUE_DEPTH)) begin
            wr_o.en   = 1'b1;
            wr_o.addr = commit_q;
            wr_o.data = req_i.rx_byte;
            pend_d    = lpdq_pkg::ptr_adv(commit_q);
          end
          phase_d = lpdq_pkg::PH_LEN_HI;
        end
        lpdq_pkg::PH_LEN_HI: begin
          pkt_len_d = len_hi;
          if (len_hi < lpdq_pkg::MIN_LEN || len_hi > max_len_i) begin
            rx_status_o = lpdq_pkg::ST_CORRUPT;
            pend_d      = commit_q;
            phase_d     = lpdq_pkg::PH_LEN_LO;
          end else begin
            left_d = len_hi - lpdq_pkg::MIN_LEN;
            if (no_room) begin
              rx_status_o = lpdq_pkg::ST_DROP;
              pend_d      = commit_q;
            end else begin
              wr_o.en   = 1'b1;
              wr_o.addr = pend_q;
              wr_o.data = req_i.rx_byte;
              pend_d    = lpdq_pkg::ptr_adv(pend_q);
            end
            if (len_hi == lpdq_pkg::MIN_LEN) begin
              // header-only packet
              if (!no_room) begin
                commit_d    = pend_d;
                count_d     = count_q + lpdq_pkg::CNT_W'(len_hi);
                rx_status_o = lpdq_pkg::ST_COMMIT;
              end
              drop_d  = 1'b0;
              phase_d = lpdq_pkg::PH_LEN_LO;
            end else begin
              drop_d  = no_room;
              phase_d = lpdq_pkg::PH_BODY;
            end
          end
        end
        lpdq_pkg::PH_BODY: begin
          if (!drop_q) begin
            wr_o.en   = 1'b1;
            wr_o.addr = pend_q;
            wr_o.data = req_i.rx_byte;
            pend_d    = lpdq_pkg::ptr_adv(pend_q);
          end
          left_d = left_dec;
          if (left_dec == '0) begin
            if (!drop_q) begin
              commit_d    = pend_d;
              count_d     = count_q + lpdq_pkg::CNT_W'(pkt_len_q);
              rx_status_o = lpdq_pkg::ST_COMMIT;
            end
            drop_d  = 1'b0;
            phase_d = lpdq_pkg::PH_LEN_LO;
          end
        end
        default: begin
          phase_d = lpdq_pkg::PH_LEN_LO;
        end
      endcase
    end

    if (req_i.pop) begin
      rd_d    = lpdq_pkg::ptr_adv(rd_q);
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      commit_q  <= '0;
      pend_q    <= '0;
      rd_q      <= '0;
      count_q   <= '0;
      phase_q   <= lpdq_pkg::PH_LEN_LO;
      pkt_len_q <= '0;
      left_q    <= '0;
      drop_q    <= 1'b0;
    end else begin
      commit_q  <= commit_d;
      pend_q    <= pend_d;
      rd_q      <= rd_d;
      count_q   <= count_d;
      phase_q   <= phase_d;
      pkt_len_q <= pkt_len_d;
      left_q    <= left_d;
      drop_q    <= drop_d;
    end
  end

  assign rd_ptr_o     = rd_q;
  assign count_o      = count_q;
  assign count_next_o = count_d;

  `LPDQ_INVARIANT(a_count_bound, clk_i, rst_ni, count_q <= lpdq_pkg::CNT_W'(lpdq_pkg::QUEUE_DEPTH), "committed count above ring depth")
  `LPDQ_ASSERT(a_no_write_full, clk_i, rst_ni, wr_o.en |-> count_q < lpdq_pkg::CNT_W'(lpdq_pkg::QUEUE_DEPTH), "ring write while all entries are committed")
  `LPDQ_ASSERT(a_pop_dec, clk_i, rst_ni, req_i.pop |=> count_q == $past(count_q) - 1'b1, "pop did not take one byte off the count")
  `LPDQ_ASSERT(a_pop_nonempty, clk_i, rst_ni, req_i.pop |-> count_q != '0, "pop on empty ring")

endmodule

`default_nettype wire

// ----- src/lpdq_out.sv -----
// Read-data stage, report framing of popped bytes, and output register.
`default_nettype none
`include "assert_macros.svh"

module lpdq_out (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          acc_i,
  input  wire lpdq_pkg::item_t               item_i,
  input  wire logic [lpdq_pkg::BYTE_W-1:0]   rdata_i,
  output logic                               ready_o,
  lpdq_out_if.source                         out_o
);

  logic                        s1_valid_q;
  lpdq_pkg::item_t             s1_item_q;
  logic                        load_out;
  logic                        is_read;

  lpdq_pkg::phase_e            rphase_q, rphase_d;
  logic [lpdq_pkg::BYTE_W-1:0] rlo_q, rlo_d;
  logic [lpdq_pkg::LEN_W-1:0]  rleft_q, rleft_d;
  logic [lpdq_pkg::LEN_W-1:0]  rlen;
  logic [lpdq_pkg::LEN_W-1:0]  rleft_dec;
  logic                        last;

  logic                          out_valid_q;
  logic [lpdq_pkg::STATUS_W-1:0] out_status_q;
  logic [lpdq_pkg::BYTE_W-1:0]   out_data_q;
  logic                          out_last_q;
  logic [lpdq_pkg::COUNT_OUT_W-1:0] out_count_q;

  assign load_out  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign ready_o   = !s1_valid_q || load_out;
  assign is_read   = s1_item_q.status == lpdq_pkg::ST_READ;
  assign rlen      = {rdata_i, rlo_q};
  assign rleft_dec = rleft_q - 1'b1;

  always_comb begin
    rphase_d = rphase_q;
    rlo_d    = rlo_q;
    rleft_d  = rleft_q;
    last     = 1'b0;
    if (is_read) begin
      case (rphase_q)
        lpdq_pkg::PH_LEN_LO: begin
          rlo_d    = rdata_i;
          rphase_d = lpdq_pkg::PH_LEN_HI;
        end
        lpdq_pkg::PH_LEN_HI: begin
          rleft_d = (rlen >= lpdq_pkg::MIN_LEN) ? rlen - lpdq_pkg::MIN_LEN : '0;
          if (rlen <= lpdq_pkg::MIN_LEN) begin
            last     = 1'b1;
            rphase_d = lpdq_pkg::PH_LEN_LO;
          end else begin
            rphase_d = lpdq_pkg::PH_BODY;
          end
        end
        lpdq_pkg::PH_BODY: begin
          rleft_d = rleft_dec;
          if (rleft_dec == '0) begin
            last     = 1'b1;
            rphase_d = lpdq_pkg::PH_LEN_LO;
          end
        end
        default: begin
          rphase_d = lpdq_pkg::PH_LEN_LO;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rphase_q    <= lpdq_pkg::PH_LEN_LO;
      rlo_q       <= '0;
      rleft_q     <= '0;
    end else begin
      if (ready_o) begin
        s1_valid_q <= acc_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        rphase_q    <= rphase_d;
        rlo_q       <= rlo_d;
        rleft_q     <= rleft_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && acc_i) begin
      s1_item_q <= item_i;
    end
    if (load_out) begin
      out_status_q <= s1_item_q.status;
      out_data_q   <= is_read ? rdata_i : '0;
      out_last_q   <= last;
      out_count_q  <= s1_item_q.committed;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.read_data       = out_data_q;
  assign out_o.last_of_report  = out_last_q;
  assign out_o.committed_bytes = out_count_q;

  `LPDQ_INVARIANT(a_body_left, clk_i, rst_ni, rphase_q != lpdq_pkg::PH_BODY || rleft_q != '0, "report body with no bytes left")
  `LPDQ_ASSERT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !load_out |=> s1_valid_q && $stable(s1_item_q), "stalled request lost in read-data stage")

endmodule

`default_nettype wire

// ----- src/length_prefixed_packet_deframer_queue_core.sv -----
// Top level of the length-prefixed packet deframer queue.
`default_nettype none

// Usage
//   in_i   : one request per handshake. kind = 0 carries a received link byte
//            (rx_byte); kind = 1 pops one committed byte from the queue.
//   out_o  : exactly one result per request, in request order: status,
//            read_data, last_of_report and the committed byte count left.
//   cfg_we_i/cfg_wdata_i : writes max_packet_length; write only while idle.
// Path: a result is registered with the ring read data in the read-data
//   stage, then in the output register.
// Throughput: one request per cycle unless out_o stalls; one write and one
//   read ring port, a received byte writes and a pop reads in its own cycle.
// Stall: when out_o.ready is low, one result waits in the output register
//   and one more in the read-data stage; in_i.ready drops only when both
//   are full, so nothing is lost or repeated.
// Reset: rst_ni clears pointers, counts, parse state and the limit (8205).
//   The byte ring itself is not cleared; only committed entries are read,
//   so the block takes requests in the first cycle after reset.

module length_prefixed_packet_deframer_queue_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lpdq_pkg::LEN_W-1:0]       cfg_wdata_i,
  lpdq_in_if.sink                               in_i,
  lpdq_out_if.source                            out_o
);

  logic [lpdq_pkg::LEN_W-1:0]  max_len_q;

  logic                        accept;
  logic                        stage_ready;
  lpdq_pkg::ctl_req_t          req;
  lpdq_pkg::status_e           rx_status;
  lpdq_pkg::ring_wr_t          ring_wr;
  logic [lpdq_pkg::ADDR_W-1:0] rd_ptr;
  logic [lpdq_pkg::CNT_W-1:0]  count;
  logic [lpdq_pkg::CNT_W-1:0]  count_next;
  lpdq_pkg::item_t             item;
  logic [lpdq_pkg::BYTE_W-1:0] ring_rdata;

  // Packet length limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= lpdq_pkg::MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = stage_ready;
  assign accept     = in_i.valid && stage_ready;

  // A pop on an empty ring leaves all read state alone.
  assign req.rx_en   = accept && (in_i.kind == lpdq_pkg::KIND_RX);
  assign req.pop     = accept && (in_i.kind == lpdq_pkg::KIND_READ) && (count != '0);
  assign req.rx_byte = in_i.rx_byte;

  lpdq_ctl u_ctl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_len_i    (max_len_q),
    .req_i        (req),
    .rx_status_o  (rx_status),
    .wr_o         (ring_wr),
    .rd_ptr_o     (rd_ptr),
    .count_o      (count),
    .count_next_o (count_next)
  );

  // Byte ring; read data of a pop shows up in the following cycle.
  lpdq_ram #(
    .WIDTH (lpdq_pkg::BYTE_W),
    .DEPTH (lpdq_pkg::QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_wr.en),
    .waddr_i (ring_wr.addr),
    .wdata_i (ring_wr.data),
    .re_i    (req.pop),
    .raddr_i (rd_ptr),
    .rdata_o (ring_rdata)
  );

  always_comb begin
    // Count reported after this request, cut to the output field width.
    item.committed = lpdq_pkg::COUNT_OUT_W'(count_next);
    if (in_i.kind == lpdq_pkg::KIND_RX) begin
      item.status = rx_status;
    end else if (count == '0) begin
      item.status = lpdq_pkg::ST_EMPTY;
    end else begin
      item.status = lpdq_pkg::ST_READ;
    end
  end

  lpdq_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (accept),
    .item_i  (item),
    .rdata_i (ring_rdata),
    .ready_o (stage_ready),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for the length-prefixed packet deframer queue: directed and random traffic.
`timescale 1ns / 100ps

module tb;
  import lpdq_pkg::*;

  // Share of cycles in which a side idles, in percent.
  localparam int unsigned IDLE_PCT = 35;
  // Requests per random phase.
  localparam int unsigned PHASE_REQUESTS = 240;

  // One result as the block should deliver it.
  typedef struct packed {
    status_e     status;
    logic [7:0]  read_data;
    logic        ends_report;
    logic [14:0] committed;
  } outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [LEN_W-1:0]     cfg_wdata_i;

  lpdq_in_if  req_if ();
  lpdq_out_if res_if ();

  length_prefixed_packet_deframer_queue_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (res_if)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the block: ring, pointers, parser and reader state.
  // Ring entries start unknown; only committed entries are ever looked up.
  // ---------------------------------------------------------------------------
  logic [7:0]   ring_mirror [QUEUE_DEPTH];
  int unsigned  commit_ptr   = 0;
  int unsigned  pend_ptr     = 0;
  int unsigned  rd_ptr       = 0;
  int unsigned  queued_count = 0;   // committed bytes waiting to be popped
  phase_e       rx_phase     = PH_LEN_LO;
  logic [15:0]  pkt_len      = '0;
  logic [15:0]  rx_left      = '0;
  logic         dropping     = 1'b0;
  phase_e       rd_phase     = PH_LEN_LO;
  logic [7:0]   rd_len_lo    = '0;
  logic [15:0]  rd_left      = '0;
  logic [15:0]  max_len      = MAX_LEN_RESET;

  outcome_t     outcomes_due [$];   // results owed by the block, oldest first
  outcome_t     due;
  int unsigned  requests_sent  = 0;
  int unsigned  mismatch_count = 0;
  bit           steady_run     = 1'b0;  // no idling on either side while set

  function automatic int unsigned wrap_inc(input int unsigned p);
    return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
  endfunction

  // Write a packet byte at the pending (not yet visible) position.
  function automatic void stage_byte(input logic [7:0] b);
    ring_mirror[pend_ptr] = b;
    pend_ptr = wrap_inc(pend_ptr);
  endfunction

  // Advance the shadow by one accepted request and return what it yields.
  function automatic outcome_t next_outcome(input logic kind, input logic [7:0] b);
    outcome_t    o;
    logic [15:0] hdr_len;
    o.status      = ST_TAKEN;
    o.read_data   = '0;
    o.ends_report = 1'b0;
    if (kind == KIND_RX) begin
      case (rx_phase)
        PH_LEN_LO: begin
          // A new packet restarts at the commit point; the low length byte
          // only lands in the ring when there is a free slot for it.
          pkt_len  = {8'h00, b};
          pend_ptr = commit_ptr;
          if (queued_count < QUEUE_DEPTH) stage_byte(b);
          rx_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          pkt_len = {b, pkt_len[7:0]};
          if (pkt_len < MIN_LEN || pkt_len > max_len) begin
            // Corrupt length: discard and parse the next byte as a header.
            o.status = ST_CORRUPT;
            pend_ptr = commit_ptr;
            rx_phase = PH_LEN_LO;
          end else begin
            rx_left = pkt_len - MIN_LEN;
            // Free space is judged once, when the length is known.
            if (pkt_len > QUEUE_DEPTH - queued_count) begin
              o.status = ST_DROP;
              dropping = 1'b1;
              pend_ptr = commit_ptr;
            end else begin
              dropping = 1'b0;
              stage_byte(b);
            end
            if (rx_left == 0) begin
              // Header-only packet completes on its high byte.
              if (!dropping) begin
                commit_ptr   = pend_ptr;
                queued_count += pkt_len;
                o.status     = ST_COMMIT;
              end
              dropping = 1'b0;
              rx_phase = PH_LEN_LO;
            end else begin
              rx_phase = PH_BODY;
            end
          end
        end
        default: begin
          if (!dropping) stage_byte(b);
          rx_left = rx_left - 1'b1;
          if (rx_left == 0) begin
            if (!dropping) begin
              commit_ptr   = pend_ptr;
              queued_count += pkt_len;
              o.status     = ST_COMMIT;
            end
            dropping = 1'b0;
            rx_phase = PH_LEN_LO;
          end
        end
      endcase
    end else if (queued_count == 0) begin
      o.status = ST_EMPTY;
    end else begin
      // Pop one committed byte and track report boundaries from its header.
      o.status    = ST_READ;
      o.read_data = ring_mirror[rd_ptr];
      rd_ptr      = wrap_inc(rd_ptr);
      queued_count--;
      case (rd_phase)
        PH_LEN_LO: begin
          rd_len_lo = o.read_data;
          rd_phase  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          hdr_len = {o.read_data, rd_len_lo};
          rd_left = (hdr_len >= MIN_LEN) ? hdr_len - MIN_LEN : '0;
          if (rd_left == 0) begin
            o.ends_report = 1'b1;
            rd_phase      = PH_LEN_LO;
          end else begin
            rd_phase = PH_BODY;
          end
        end
        default: begin
          rd_left = rd_left - 1'b1;
          if (rd_left == 0) begin
            o.ends_report = 1'b1;
            rd_phase      = PH_LEN_LO;
          end
        end
      endcase
    end
    o.committed = queued_count[14:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Every result taken is matched against the oldest outstanding request.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding, status %0d",
                                  res_if.status));
      end else begin
        due = outcomes_due.pop_front();
        if (res_if.status !== due.status)
          report_mismatch($sformatf("status %0d, want %0d", res_if.status, due.status));
        if (res_if.read_data !== due.read_data)
          report_mismatch($sformatf("read_data %0h, want %0h", res_if.read_data,
                                    due.read_data));
        if (res_if.last_of_report !== due.ends_report)
          report_mismatch($sformatf("last_of_report %0b, want %0b", res_if.last_of_report,
                                    due.ends_report));
        if (res_if.committed_bytes !== due.committed)
          report_mismatch($sformatf("committed_bytes %0d, want %0d",
                                    res_if.committed_bytes, due.committed));
      end
    end
  end

  // Result side backpressure: random stalls, none during a steady stretch.
  always @(negedge clk_i) begin
    res_if.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Request side. All tasks start and end at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one request; valid stays up on return so back-to-back requests
  // do not bubble. Whoever stops sending lowers it.
  task automatic send_request(input logic kind, input logic [7:0] b);
    if (!steady_run) begin
      // Idle cycles one at a time, so about a third of all cycles are idle.
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        req_if.valid = 1'b0;
        @(negedge clk_i);
      end
    end
    req_if.valid   = 1'b1;
    req_if.kind    = kind;
    req_if.rx_byte = b;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    outcomes_due.push_back(next_outcome(kind, b));
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Read request squeezed in between received bytes, at the given odds.
  task automatic interleave_read(input int unsigned read_pct);
    if ($urandom_range(0, 99) < read_pct) send_request(KIND_READ, 8'($urandom_range(0, 255)));
  endtask

  // Header with the given length, then random body bytes.
  task automatic send_packet(input int unsigned len, input int unsigned read_pct);
    int unsigned i;
    send_request(KIND_RX, len[7:0]);
    interleave_read(read_pct);
    send_request(KIND_RX, len[15:8]);
    for (i = 2; i < len; i++) begin
      interleave_read(read_pct);
      send_request(KIND_RX, 8'($urandom_range(0, 255)));
    end
  endtask

  // Pop until the shadow says the queue is empty.
  task automatic drain_reads();
    while (queued_count != 0) send_request(KIND_READ, 8'($urandom_range(0, 255)));
  endtask

  // Feed filler until the parser waits for a fresh header again.
  task automatic resync_parser();
    while (rx_phase != PH_LEN_LO) send_request(KIND_RX, 8'($urandom_range(0, 255)));
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register write; only called with nothing in flight.
  task automatic write_max_len(input logic [15:0] value);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    max_len  = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Header corner cases under the reset limit, reads on an empty queue and
  // a read while a packet is still arriving.
  task automatic test_framing_cases();
    send_request(KIND_READ, 8'hFF);          // empty queue
    send_packet(2, 0);                       // header only, commits on high byte
    send_request(KIND_RX, 8'h00);            // length zero
    send_request(KIND_RX, 8'h00);
    send_request(KIND_RX, 8'h01);            // length one
    send_request(KIND_RX, 8'h00);
    send_request(KIND_RX, 8'hFF);            // largest length, over the limit
    send_request(KIND_RX, 8'hFF);
    send_request(KIND_RX, 8'h0E);            // one past the reset limit
    send_request(KIND_RX, 8'h20);
    send_request(KIND_RX, 8'h05);            // normal packet, extreme body bytes
    send_request(KIND_RX, 8'h00);
    send_request(KIND_RX, 8'h00);
    send_request(KIND_RX, 8'hFF);
    send_request(KIND_RX, 8'h80);
    send_request(KIND_RX, 8'h04);            // read pops only committed bytes
    send_request(KIND_RX, 8'h00);
    send_request(KIND_RX, 8'hAA);
    send_request(KIND_READ, 8'h00);
    send_request(KIND_RX, 8'h55);
    drain_reads();
    send_request(KIND_READ, 8'h5A);          // empty again
    wait_drained();
  endtask

  // Limit at its reset value, at its floor and at a middle value.
  task automatic test_length_limit();
    send_packet(MAX_LEN_RESET, 0);           // exactly the reset limit
    drain_reads();
    wait_drained();
    write_max_len(MIN_LEN);                  // only header-only packets pass
    send_packet(3, 0);                       // corrupt, then body bytes reparse
    resync_parser();
    send_packet(2, 0);
    wait_drained();
    write_max_len(16'd300);
    send_packet(300, 20);
    send_request(KIND_RX, 8'h2D);            // 301: corrupt
    send_request(KIND_RX, 8'h01);
    drain_reads();
    wait_drained();
  endtask

  // Fill the ring completely, then hit the drop path with full and nearly
  // full queues; draining wraps the pointers.
  task automatic test_queue_full();
    write_max_len(16'hFFFF);
    send_packet(QUEUE_DEPTH, 0);             // fills every slot
    send_packet(2, 0);                       // no room at all, low byte not stored
    send_packet(5, 0);                       // dropped, body swallowed
    repeat (3) send_request(KIND_READ, 8'($urandom_range(0, 255)));
    send_packet(3, 0);                       // fits exactly into the freed space
    send_packet(4, 10);                      // too long for the space left, dropped
    drain_reads();
    send_request(KIND_READ, 8'h00);
    wait_drained();
  endtask

  // Random packets with interleaved reads over several limits; corrupt
  // headers everywhere and stray bytes only where lengths stay short.
  task automatic test_random_traffic();
    logic [15:0] limits [5];
    int unsigned p, stop, pick, len, cap;
    limits = '{MAX_LEN_RESET, MIN_LEN, 16'hFFFF, 16'd40, 16'($urandom_range(2, 65535))};
    for (p = 0; p < 5; p++) begin
      wait_drained();
      write_max_len(limits[p]);
      steady_run = (p == 2);                 // one stretch at full rate
      cap  = (max_len > 300) ? 300 : max_len;
      stop = requests_sent + PHASE_REQUESTS;
      while (requests_sent < stop) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // Bad length header.
          if (max_len == 16'hFFFF || $urandom_range(0, 1) == 0) begin
            len = $urandom_range(0, 1);
          end else begin
            len = $urandom_range(max_len + 1, 65535);
          end
          send_request(KIND_RX, len[7:0]);
          send_request(KIND_RX, len[15:8]);
        end else if (pick < 12 && max_len <= 300) begin
          // Stray byte breaks the framing of what follows.
          send_request(KIND_RX, 8'($urandom_range(0, 255)));
        end else if (pick < 20) begin
          send_request(KIND_READ, 8'($urandom_range(0, 255)));
        end else begin
          if ($urandom_range(0, 99) < 85) begin
            len = $urandom_range(2, (cap < 24) ? cap : 24);
          end else begin
            len = $urandom_range(2, cap);
          end
          send_packet(len, 30);
        end
      end
      resync_parser();
      steady_run = 1'b0;
    end
    drain_reads();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.kind    = KIND_RX;
    req_if.rx_byte = '0;
    res_if.ready   = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_framing_cases();
    test_length_limit();
    test_queue_full();
    test_random_traffic();

    // Let the output pipeline settle before the verdict.
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
